### hdl/plf_pkg.sv
// Shared constants, item and result types and the limit clamp for the line framer.
// No dependencies; every other file of the framer but plf_ram uses this package.
package plf_pkg;

  localparam int CONNECTIONS = 1024;
  localparam int LINE_BYTES  = 2048;

  localparam int CONN_ID_W = 10;
  localparam int BYTE_W    = 8;
  localparam int MLEN_W    = 12;
  localparam int CFG_W     = 12;

  localparam int ADDR_W = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
  localparam int LEN_W  = $clog2(LINE_BYTES + 1);

  localparam logic [BYTE_W-1:0] NEWLINE   = 8'h0A;
  localparam logic [CFG_W-1:0]  LIMIT_RST = 12'd2048;

  typedef struct packed {
    logic [CONN_ID_W-1:0] conn_id;
    logic [BYTE_W-1:0]    data_byte;
    logic                 segment_end;
    logic                 new_conn;
  } plf_item_t;

  typedef struct packed {
    logic [CONN_ID_W-1:0] out_conn;
    logic [BYTE_W-1:0]    out_byte;
    logic                 byte_valid;
    logic                 message_end;
    logic                 truncated;
    logic [MLEN_W-1:0]    message_length;
  } plf_result_t;

  // A limit of zero acts as one, and anything above the line buffer size
  // acts as the buffer size.
  function automatic logic [LEN_W-1:0] limit_clamp(input logic [CFG_W-1:0] v);
    logic [LEN_W-1:0] lim;
    if (v == '0) begin
      lim = LEN_W'(1);
    end else if (int'(v) > LINE_BYTES) begin
      lim = LEN_W'(LINE_BYTES);
    end else begin
      lim = LEN_W'(v);
    end
    return lim;
  endfunction

endpackage

### hdl/plf_in_if.sv
// Input channel of the line framer: valid/ready handshake with one payload byte.
// Depends on plf_pkg for the field widths.
interface plf_in_if;
  logic                           valid;
  logic                           ready;
  logic [plf_pkg::CONN_ID_W-1:0]  conn_id;
  logic [plf_pkg::BYTE_W-1:0]     data_byte;
  logic                           segment_end;
  logic                           new_conn;

  modport source (output valid, output conn_id, output data_byte, output segment_end,
                  output new_conn, input ready);
  modport sink (input valid, input conn_id, input data_byte, input segment_end,
                input new_conn, output ready);
endinterface

### hdl/plf_out_if.sv
// Result channel of the line framer: valid/ready handshake with one framed result.
// Depends on plf_pkg for the field widths.
interface plf_out_if;
  logic                           valid;
  logic                           ready;
  logic [plf_pkg::CONN_ID_W-1:0]  out_conn;
  logic [plf_pkg::BYTE_W-1:0]     out_byte;
  logic                           byte_valid;
  logic                           message_end;
  logic                           truncated;
  logic [plf_pkg::MLEN_W-1:0]     message_length;

  modport source (output valid, output out_conn, output out_byte, output byte_valid,
                  output message_end, output truncated, output message_length,
                  input ready);
  modport sink (input valid, input out_conn, input out_byte, input byte_valid,
                input message_end, input truncated, input message_length,
                output ready);
endinterface

### hdl/plf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; read during a write to the same address returns the old data.
module plf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/plf_len_update.sv
// Per-byte framing decision: next message length, passed byte and message end.
// Depends on plf_pkg for the item and result types and the newline code.
module plf_len_update (
  input  plf_pkg::plf_item_t          item,
  input  logic [plf_pkg::LEN_W-1:0]   cur_len,
  input  logic [plf_pkg::LEN_W-1:0]   limit,
  output plf_pkg::plf_result_t        res,
  output logic                        wr_en,
  output logic [plf_pkg::LEN_W-1:0]   wr_len
);
  import plf_pkg::*;

  logic             in_range;
  logic [LEN_W-1:0] len0;
  logic [LEN_W-1:0] len1;
  logic             keep;
  logic             trunc;

  assign in_range = int'(item.conn_id) < CONNECTIONS;
  assign len0     = item.new_conn ? '0 : cur_len;
  assign keep     = len0 < limit;
  assign len1     = keep ? len0 + LEN_W'(1) : len0;
  assign trunc    = item.segment_end && (len1 >= limit);

  always_comb begin
    res          = '0;
    res.out_conn = item.conn_id;
    wr_en        = 1'b0;
    wr_len       = '0;
    if (in_range) begin
      wr_en = 1'b1;
      if (item.data_byte == NEWLINE) begin
        // A newline closes the message, possibly empty, and is not passed on.
        res.message_end    = 1'b1;
        res.message_length = MLEN_W'(len0);
      end else begin
        if (keep) begin
          res.out_byte   = item.data_byte;
          res.byte_valid = 1'b1;
        end
        if (trunc) begin
          res.message_end    = 1'b1;
          res.truncated      = 1'b1;
          res.message_length = MLEN_W'(len1);
        end else begin
          wr_len = len1;
        end
      end
    end
  end

endmodule

### hdl/per_connection_line_framer.sv
// Top level of the per-connection line framer.
// Depends on plf_pkg, plf_in_if, plf_out_if, plf_ram and plf_len_update.

// The framer takes one payload byte per transfer and returns exactly one result per byte,
// sustaining one transfer per clock cycle while the output is not stalled. A taken byte
// is held in stage 1 while its length memory read runs: the edge that takes the byte
// also starts that read. Its framing decision is then registered into the output
// register once that register is free. The per-connection message lengths live in a
// single 1024 x 12 synchronous RAM that is read when a byte is taken and written back
// when its result is registered; a write-forwarding register covers a byte that follows
// another byte of the same connection. After reset the block runs a clearing pass over
// all 1024 entries, one RAM entry per cycle, and holds in_chan.ready low until it is
// done. The line limit register may be written at any time, but is meant to be changed
// only while the framer is idle; the value written is clamped to 1..2048.
module per_connection_line_framer (
  input  logic                       clk,
  input  logic                       rst_n,
  plf_in_if.sink                     in_chan,
  plf_out_if.source                  out_chan,
  input  logic                       cfg_we,
  input  logic [plf_pkg::CFG_W-1:0]  cfg_wdata
);
  import plf_pkg::*;

  // Clearing pass state.
  logic              clearing_r;
  logic [ADDR_W-1:0] clr_addr_r;

  // Effective (clamped) line limit.
  logic [LEN_W-1:0]  limit_r;

  // Stage 1: the byte whose length is being read from the RAM.
  logic              s1_valid_r;
  logic              s1_valid_nxt;
  plf_item_t         s1_item_r;

  // Output register.
  logic              out_valid_r;
  logic              out_valid_nxt;
  plf_result_t       out_res_r;

  // Most recent length write-back, used to forward past the RAM read latency.
  logic              fwd_valid_r;
  logic [ADDR_W-1:0] fwd_addr_r;
  logic [LEN_W-1:0]  fwd_len_r;

  logic              in_take;
  logic              s1_adv;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] s1_addr;
  logic [LEN_W-1:0]  ram_rdata;
  logic [LEN_W-1:0]  cur_len;
  plf_result_t       upd_res;
  logic              upd_wr_en;
  logic [LEN_W-1:0]  upd_wr_len;
  logic              item_we;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [LEN_W-1:0]  ram_wdata;

  // Stage 1 moves into the output register whenever that register is empty or its result
  // is being transferred out. After clearing, a new byte is taken whenever stage 1 frees up.
  assign s1_adv           = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready    = !clearing_r && (!s1_valid_r || s1_adv);
  assign in_take          = in_chan.valid && in_chan.ready;

  assign rd_addr = ADDR_W'(in_chan.conn_id);
  assign s1_addr = ADDR_W'(s1_item_r.conn_id);

  // The RAM returns old data when the read and the write-back of the byte ahead share
  // an edge, so the latest written length is taken from the forwarding register.
  assign cur_len = (fwd_valid_r && (fwd_addr_r == s1_addr)) ? fwd_len_r : ram_rdata;

  plf_len_update u_len_update (
    .item    (s1_item_r),
    .cur_len (cur_len),
    .limit   (limit_r),
    .res     (upd_res),
    .wr_en   (upd_wr_en),
    .wr_len  (upd_wr_len)
  );

  assign item_we   = s1_adv && upd_wr_en;
  assign ram_we    = clearing_r || item_we;
  assign ram_waddr = clearing_r ? clr_addr_r : s1_addr;
  assign ram_wdata = clearing_r ? '0 : upd_wr_len;

  plf_ram #(
    .WIDTH (LEN_W),
    .DEPTH (CONNECTIONS)
  ) u_len_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_take),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_addr_r  <= '0;
      limit_r     <= limit_clamp(LIMIT_RST);
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(CONNECTIONS - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      if (cfg_we) begin
        limit_r <= limit_clamp(cfg_wdata);
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (item_we) begin
        fwd_valid_r <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.conn_id     <= in_chan.conn_id;
      s1_item_r.data_byte   <= in_chan.data_byte;
      s1_item_r.segment_end <= in_chan.segment_end;
      s1_item_r.new_conn    <= in_chan.new_conn;
    end
    if (s1_adv) begin
      out_res_r <= upd_res;
    end
    if (item_we) begin
      fwd_addr_r <= s1_addr;
      fwd_len_r  <= upd_wr_len;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.out_conn       = out_res_r.out_conn;
  assign out_chan.out_byte       = out_res_r.out_byte;
  assign out_chan.byte_valid     = out_res_r.byte_valid;
  assign out_chan.message_end    = out_res_r.message_end;
  assign out_chan.truncated      = out_res_r.truncated;
  assign out_chan.message_length = out_res_r.message_length;

`ifndef ASSERT_OFF
  // A stalled byte in stage 1 must not be lost while the output waits.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_chan.ready |=> s1_valid_r)
    else $error("stage 1 byte dropped during output stall");

  // A result that does not end a message carries no length and no truncation.
  a_len_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r.message_end |->
      (out_res_r.message_length == '0) && !out_res_r.truncated)
    else $error("message length or truncation without message end");

  // A truncated message has reached the limit, which is at least one byte.
  a_trunc_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.truncated |-> out_res_r.message_length != '0)
    else $error("truncated message with zero length");

  // A written-back length never exceeds the line buffer size.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    item_we |-> upd_wr_len <= LEN_W'(LINE_BYTES))
    else $error("stored length exceeds line buffer size");

  // No byte enters while the clearing pass still owns the RAM write port.
  a_no_take_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !item_we && !s1_valid_r)
    else $error("item activity during clearing pass");
`endif

endmodule
